>>> src/pidg_pkg.sv
// Package for the gated-integral PID controller.
// Holds the field widths, the register index codes and the divider handshake type.
// No dependencies.
package pidg_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DtW      = 31;
  localparam int unsigned AccW     = 48;
  localparam int unsigned FracW    = 16;
  localparam int unsigned MagW     = DataW + 1;
  localparam int unsigned DivNumW  = 50;
  localparam int unsigned DivIter  = DivNumW / 2;
  localparam int unsigned DivCntW  = $clog2(DivIter);
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_ERROR_OFFSET = 3'd3,
    CFG_DRIVE_OFFSET = 3'd4,
    CFG_THRESHOLD    = 3'd5,
    CFG_GATE_MODE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

endpackage

>>> src/pidg_div.sv
// Radix-4 restoring divider for the derivative rate of the PID controller.
// Divides an unsigned magnitude by the time step, two quotient bits per cycle,
// then applies the sign and saturates to 32 bits. Depends on pidg_pkg.
module pidg_div import pidg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  input  logic [MagW-1:0]         mag_i,
  input  logic [DtW-1:0]          den_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] quot_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } div_state_e;

  div_state_e               state_q;
  logic [DivCntW-1:0]       cnt_q;
  logic                     done_q;
  logic [DivNumW-1:0]       dvd_q;
  logic [DtW-1:0]           rem_q;
  logic [DtW-1:0]           den_q;
  logic                     neg_q;
  logic signed [DataW-1:0]  quot_q;

  logic [DtW:0]             r1;
  logic [DtW:0]             r2;
  logic [DtW:0]             r1s;
  logic [DtW:0]             r2s;
  logic                     ge1;
  logic                     ge2;
  logic [DataW-1:0]         sat_val;

  always_comb begin
    r1  = {rem_q, dvd_q[DivNumW-1]};
    ge1 = r1 >= {1'b0, den_q};
    r1s = ge1 ? r1 - {1'b0, den_q} : r1;
    r2  = {r1s[DtW-1:0], dvd_q[DivNumW-2]};
    ge2 = r2 >= {1'b0, den_q};
    r2s = ge2 ? r2 - {1'b0, den_q} : r2;
  end

  always_comb begin
    if (neg_q) begin
      if (dvd_q > {{(DivNumW-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}}) begin
        sat_val = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        sat_val = -dvd_q[DataW-1:0];
      end
    end else begin
      if (dvd_q > {{(DivNumW-DataW+1){1'b0}}, {(DataW-1){1'b1}}}) begin
        sat_val = {1'b0, {(DataW-1){1'b1}}};
      end else begin
        sat_val = dvd_q[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else if (req_i.start) begin
      state_q <= D_RUN;
      cnt_q   <= DivCntW'(DivIter - 1);
      done_q  <= 1'b0;
      dvd_q   <= {1'b0, mag_i, {FracW{1'b0}}};
      rem_q   <= '0;
      den_q   <= den_i;
      neg_q   <= req_i.neg;
    end else begin
      unique case (state_q)
        D_IDLE: begin
        end
        D_RUN: begin
          dvd_q <= {dvd_q[DivNumW-3:0], ge1, ge2};
          rem_q <= r2s[DtW-1:0];
          if (cnt_q == '0) begin
            state_q <= D_FIX;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        D_FIX: begin
          quot_q  <= $signed(sat_val);
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/pid_controller_with_integral_gate_core.sv
// Top level of the gated-integral PID controller: config registers, microcode
// sequencer, shared 32x33 multiplier, accumulators and output register.
// Depends on pidg_pkg and pidg_div.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   target_i, sample_i, step_time_i
//  out      output     out_valid_o/out_stall_i drive_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item runs from accept to result through the microcode steps, waiting on the rate
// divider's two-bit steps and its sign/saturate step; the next item is taken in the cycle
// after the result is loaded. Reset clears the config registers, the integral and the
// previous error. A stalled result holds in the output register while the next item is
// already being worked; the last step waits for the slot.
module pid_controller_with_integral_gate_core import pidg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] target_i,
  input  logic signed [DataW-1:0] sample_i,
  input  logic [DtW-1:0]          step_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] drive_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [DataW-1:0]        cfg_wdata_i
);

  localparam int unsigned Steps  = 11;
  localparam int unsigned PcW    = $clog2(Steps);
  localparam int unsigned ProdW  = DataW + MagW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned IntegW = AccW + 2;
  localparam int unsigned ErrW   = DataW + 2;

  typedef enum logic [1:0] { A_ERR, A_GP, A_GI, A_GD } a_sel_e;
  typedef enum logic [2:0] { B_DT, B_ERR, B_AHI, B_ALO, B_RATE } b_sel_e;
  typedef enum logic [1:0] { SUM_KEEP, SUM_INIT, SUM_ADD_SH, SUM_ADD } sum_op_e;
  typedef enum logic [1:0] { C_ALWAYS, C_IN, C_DIV, C_OUT } cond_e;

  typedef struct packed {
    logic    err_ld;
    logic    div_go;
    logic    integ;
    logic    mul_en;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    sum_op_e sum_op;
    logic    out_ld;
    cond_e   cond;
    logic    last;
  } ctrl_t;

  function automatic ctrl_t rom_word(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      4'd0:  w.cond = C_IN;
      4'd1:  begin w.err_ld = 1'b1; w.sum_op = SUM_INIT; end
      4'd2:  begin w.div_go = 1'b1; w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_DT; end
      4'd3:  begin w.integ = 1'b1; w.mul_en = 1'b1; w.a_sel = A_GP; w.b_sel = B_ERR; end
      4'd4:  begin
        w.sum_op = SUM_ADD_SH; w.mul_en = 1'b1; w.a_sel = A_GI; w.b_sel = B_AHI;
      end
      4'd5:  begin
        w.sum_op = SUM_ADD; w.mul_en = 1'b1; w.a_sel = A_GI; w.b_sel = B_ALO;
      end
      4'd6:  w.sum_op = SUM_ADD_SH;
      4'd7:  w.cond = C_DIV;
      4'd8:  begin w.mul_en = 1'b1; w.a_sel = A_GD; w.b_sel = B_RATE; end
      4'd9:  w.sum_op = SUM_ADD_SH;
      4'd10: begin w.out_ld = 1'b1; w.cond = C_OUT; w.last = 1'b1; end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  logic signed [DataW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic signed [DataW-1:0]  err_off_q, drv_off_q, thr_q;
  logic                     gate_q;

  logic [PcW-1:0]           pc_q, pc_d;
  ctrl_t                    cw;
  logic                     cond_ok;
  logic                     adv;
  logic                     in_acc;

  logic signed [DataW-1:0]  target_q, sample_q;
  logic [DtW-1:0]           dt_q;
  logic signed [DataW-1:0]  err_q, prev_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [SumW-1:0]   sum_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [DataW-1:0]  drive_q;

  logic signed [ErrW-1:0]   err_sum;
  logic signed [DataW-1:0]  err_sat;
  logic signed [IntegW-1:0] integ_sum;
  logic signed [AccW-1:0]   integ_sat;
  logic signed [DataW-1:0]  drive_sat;
  logic signed [DataW-1:0]  a_op;
  logic signed [MagW-1:0]   b_op;
  logic signed [ProdW-1:0]  mul_res;
  logic signed [MagW-1:0]   diff;
  logic [MagW-1:0]          diff_mag;
  logic signed [DataW-1:0]  rate_eff;
  logic signed [DataW-1:0]  div_quot;
  logic                     div_done;
  div_req_t                 div_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      err_off_q <= '0;
      drv_off_q <= '0;
      thr_q     <= '0;
      gate_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:       gain_p_q  <= $signed(cfg_wdata_i);
        CFG_GAIN_I:       gain_i_q  <= $signed(cfg_wdata_i);
        CFG_GAIN_D:       gain_d_q  <= $signed(cfg_wdata_i);
        CFG_ERROR_OFFSET: err_off_q <= $signed(cfg_wdata_i);
        CFG_DRIVE_OFFSET: drv_off_q <= $signed(cfg_wdata_i);
        CFG_THRESHOLD:    thr_q     <= $signed(cfg_wdata_i);
        CFG_GATE_MODE:    gate_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cw         = rom_word(pc_q);
  assign in_stall_o = (pc_q != '0);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_IN:     cond_ok = in_valid_i;
      C_DIV:    cond_ok = div_done;
      C_OUT:    cond_ok = !out_valid_q || !out_stall_i;
      default:  cond_ok = 1'b1;
    endcase
  end

  assign adv = cond_ok;

  always_comb begin
    pc_d = pc_q;
    if (adv) begin
      pc_d = cw.last ? '0 : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  // error, saturated to 32 bits
  always_comb begin
    err_sum = ErrW'(target_q) - ErrW'(sample_q) + ErrW'(err_off_q);
    if (err_sum[ErrW-1:DataW-1] != {(ErrW-DataW+1){err_sum[ErrW-1]}}) begin
      err_sat = {err_sum[ErrW-1], {(DataW-1){~err_sum[ErrW-1]}}};
    end else begin
      err_sat = err_sum[DataW-1:0];
    end
  end

  // integral update, saturated to 48 bits
  always_comb begin
    integ_sum = IntegW'(acc_q) + IntegW'(prod_q >>> FracW);
    if (integ_sum[IntegW-1:AccW-1] != {(IntegW-AccW+1){integ_sum[IntegW-1]}}) begin
      integ_sat = {integ_sum[IntegW-1], {(AccW-1){~integ_sum[IntegW-1]}}};
    end else begin
      integ_sat = integ_sum[AccW-1:0];
    end
  end

  always_comb begin
    if (sum_q[SumW-1:DataW-1] != {(SumW-DataW+1){sum_q[SumW-1]}}) begin
      drive_sat = {sum_q[SumW-1], {(DataW-1){~sum_q[SumW-1]}}};
    end else begin
      drive_sat = sum_q[DataW-1:0];
    end
  end

  assign rate_eff = (dt_q == '0) ? '0 : div_quot;

  always_comb begin
    unique case (cw.a_sel)
      A_ERR:   a_op = err_q;
      A_GP:    a_op = gain_p_q;
      A_GI:    a_op = gain_i_q;
      A_GD:    a_op = gain_d_q;
      default: a_op = err_q;
    endcase
    unique case (cw.b_sel)
      B_DT:    b_op = $signed({2'b00, dt_q});
      B_ERR:   b_op = {err_q[DataW-1], err_q};
      B_AHI:   b_op = {acc_q[AccW-1], acc_q[AccW-1:FracW]};
      B_ALO:   b_op = $signed({{(MagW-FracW){1'b0}}, acc_q[FracW-1:0]});
      B_RATE:  b_op = {rate_eff[DataW-1], rate_eff};
      default: b_op = '0;
    endcase
  end

  assign mul_res = a_op * b_op;

  assign diff     = MagW'(err_q) - MagW'(prev_q);
  assign diff_mag = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);

  assign div_req.start = cw.div_go;
  assign div_req.neg   = diff[MagW-1];

  pidg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .mag_i  (diff_mag),
    .den_i  (dt_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cw.out_ld && adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        target_q <= target_i;
        sample_q <= sample_i;
        dt_q     <= step_time_i;
      end
      if (cw.err_ld) begin
        err_q <= err_sat;
      end
      if (cw.div_go) begin
        prev_q <= err_q;
      end
      if (cw.integ) begin
        if (gate_q && (target_q < thr_q)) begin
          acc_q <= '0;
        end else begin
          acc_q <= integ_sat;
        end
      end
      if (cw.mul_en) begin
        prod_q <= mul_res;
      end
      unique case (cw.sum_op)
        SUM_KEEP:   begin
        end
        SUM_INIT:   sum_q <= SumW'(drv_off_q);
        SUM_ADD_SH: sum_q <= sum_q + SumW'(prod_q >>> FracW);
        SUM_ADD:    sum_q <= sum_q + SumW'(prod_q);
        default:    begin
        end
      endcase
      if (cw.out_ld && adv) begin
        drive_q <= drive_sat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

>>> src/pidg_checker.sv
// Port-level checker for the gated-integral PID controller, bound to the top level.
// Depends on pidg_pkg and pid_controller_with_integral_gate_core.
module pidg_checker import pidg_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [DataW-1:0] drive_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared right after accept");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("sequencer not back at idle when result loaded");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(drive_o)))
    else $error("stalled result changed");

endmodule

bind pid_controller_with_integral_gate_core pidg_checker u_pidg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
